FILE: rtl/assert_macros.svh
// Assertion macros for the capture timestamp reorder queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every clock edge outside reset.
`define CSTQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition is followed by a consequence in the next cycle.
`define CSTQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/cstq_pkg.sv
// Shared constants and types of the capture timestamp reorder queue.
`timescale 1ns / 1ps
`default_nettype none
package cstq_pkg;

    localparam int DEFAULT_QUEUE_DEPTH      = 32;
    localparam int DEFAULT_MAX_PACKET_BYTES = 2048;

    localparam logic [31:0] MIN_PACKET_BYTES  = 32'd60;
    localparam logic [31:0] FLUSH_DELAY_RESET = 32'd500000000;
    // One tick is 64/10 ns, so the tick difference is shifted left by this much.
    localparam int          TICK_SHIFT        = 6;
    localparam int          MAX_RESULTS       = 32;

    // Dividing by ten: halve, then multiply by floor(2^63 / 5) and keep bits 63 and up.
    localparam int          TEN_PRE_SHIFT    = 1;
    localparam int          TEN_POST_SHIFT   = 63;
    localparam logic [63:0] RECIP_FIFTH      = 64'h1999_9999_9999_9999;
    localparam logic [31:0] FIFTH_DIVISOR    = 32'd5;
    // Splitting into seconds: drop nine bits, then divide by 1953125, which is 10^9 / 512.
    localparam int          SEC_PRE_SHIFT    = 9;
    localparam int          SEC_POST_SHIFT   = 55;
    localparam logic [63:0] RECIP_SEC_PART   = 64'h0000_0004_4B82_FA09;
    localparam logic [31:0] SEC_PART_DIVISOR = 32'd1953125;

    localparam logic [1:0] OP_PACKET = 2'd0;
    localparam logic [1:0] OP_TICK   = 2'd1;
    localparam logic [1:0] OP_DRAIN  = 2'd2;

    localparam logic [2:0] ST_QUEUED     = 3'd0;
    localparam logic [2:0] ST_BAD_LENGTH = 3'd1;
    localparam logic [2:0] ST_BEFORE     = 3'd2;
    localparam logic [2:0] ST_FULL       = 3'd3;
    localparam logic [2:0] ST_RELEASED   = 3'd4;
    localparam logic [2:0] ST_NONE       = 3'd5;

    localparam logic [1:0] EV_IN_ORDER  = 2'd0;
    localparam logic [1:0] EV_GAP       = 2'd1;
    localparam logic [1:0] EV_DISORDER  = 2'd2;
    localparam logic [1:0] EV_UNCHECKED = 2'd3;

    localparam logic [0:0] REG_CHECK_SEQUENCE = 1'd0;
    localparam logic [0:0] REG_FLUSH_DELAY    = 1'd1;

    typedef struct packed {
        logic [31:0] sec;
        logic [29:0] ns;
        logic [10:0] len;
        logic [15:0] handle;
    } entry_t;

endpackage
`default_nettype wire

FILE: rtl/capture_timestamp_reorder_queue.sv
// Packet header: a bad length or an early stamp gives its result in the next cycle.
// Otherwise two passes of the shared 32x32 multiplier (divide by ten, then split into
// seconds) and a sum; a full store then answers, else later records move up and it is
// queued. Timer tick: a multiplier pass splits the cutoff, then due records are shown in
// turn from the head; drain skips the split. Results wait until taken. One request at a
// time; reset empties the store, clears anchor, tracker and check flag, presets flush delay.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module capture_timestamp_reorder_queue #(
    parameter int QUEUE_DEPTH      = cstq_pkg::DEFAULT_QUEUE_DEPTH,
    parameter int MAX_PACKET_BYTES = cstq_pkg::DEFAULT_MAX_PACKET_BYTES
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  operation,
    input  wire logic [63:0] tick_stamp,
    input  wire logic [31:0] packet_bytes,
    input  wire logic [15:0] sequence_number,
    input  wire logic [15:0] payload_handle,
    input  wire logic [63:0] now_ns,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       status,
    output logic [1:0]       sequence_event,
    output logic [15:0]      lost_count,
    output logic [31:0]      stamp_seconds,
    output logic [29:0]      stamp_nanoseconds,
    output logic [10:0]      record_length,
    output logic [15:0]      record_handle,
    output logic             last
);
    import cstq_pkg::*;

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int PW = CW + 1;
    localparam int NW = $clog2(MAX_RESULTS + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_BACK, S_REM, S_FIX, S_SUM, S_PLACE, S_INS_RD, S_INS_CMP,
        S_REL_RD, S_REL_EVAL, S_OUT
    } state_t;

    state_t      state_reg;
    logic        check_seq_reg;
    logic [31:0] flush_delay_reg;
    logic [63:0] anchor_tick_reg;
    logic [63:0] anchor_wall_reg;
    logic [15:0] expected_reg;
    logic [CW-1:0] count_reg;
    logic [AW-1:0] head_reg;
    logic [CW-1:0] pos_reg;
    logic [NW-1:0] released_reg;
    logic        drain_all_reg;
    logic        timer_reg;
    logic        pending_valid_reg;
    entry_t      pending_reg;
    entry_t      new_entry_reg;
    logic [61:0] cutoff_reg;

    // Division by a constant: a reciprocal product built from four partial products of the
    // shared multiplier, then a back product, the remainder, and one correction step.
    logic [63:0]  div_num_reg;
    logic [63:0]  div_q_reg;
    logic [31:0]  div_rem_reg;
    logic [127:0] acc_reg;
    logic [1:0]   div_cnt_reg;
    logic         div_by_sec_reg;
    logic [63:0]  div_x;
    logic [63:0]  div_m;
    logic [31:0]  div_d;
    logic [31:0]  mul_a;
    logic [31:0]  mul_b;
    logic [1:0]   mul_sel;
    logic [63:0]  mul_p;
    logic [127:0] mul_term;
    logic [127:0] acc_next;
    logic [63:0]  div_q_est;
    logic         div_fix_ge;
    logic [63:0]  div_q_fix;
    logic [31:0]  div_rem_fix;
    logic [29:0]  div_ns;

    // Output register.
    logic [2:0]  out_status_reg;
    logic [1:0]  out_event_reg;
    logic [15:0] out_lost_reg;
    logic [31:0] out_sec_reg;
    logic [29:0] out_ns_reg;
    logic [10:0] out_len_reg;
    logic [15:0] out_handle_reg;
    logic        out_last_reg;

    // Store as a circular buffer in a memory.
    entry_t      mem [QUEUE_DEPTH];
    entry_t      mem_rd_reg;
    logic [AW-1:0] mem_raddr;
    logic [AW-1:0] mem_waddr;
    entry_t      mem_wdata;
    logic        mem_we;

    logic        bad_length;
    logic        rel_qualifies;
    logic        rd_later;

    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head, input logic [CW-1:0] idx);
        logic [PW-1:0] sum;
        sum = PW'(head) + PW'(idx);
        if (sum >= PW'(QUEUE_DEPTH))
        begin
            sum = sum - PW'(QUEUE_DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    assign div_x = div_by_sec_reg ? (div_num_reg >> SEC_PRE_SHIFT)
                                  : (div_num_reg >> TEN_PRE_SHIFT);
    assign div_m = div_by_sec_reg ? RECIP_SEC_PART : RECIP_FIFTH;
    assign div_d = div_by_sec_reg ? SEC_PART_DIVISOR : FIFTH_DIVISOR;

    always_comb
    begin
        mul_a   = div_x[31:0];
        mul_b   = div_m[31:0];
        mul_sel = 2'd0;
        case (state_reg)
            S_MUL:
            begin
                case (div_cnt_reg)
                    2'd1:
                    begin
                        mul_b   = div_m[63:32];
                        mul_sel = 2'd1;
                    end
                    2'd2:
                    begin
                        mul_a   = div_x[63:32];
                        mul_sel = 2'd1;
                    end
                    2'd3:
                    begin
                        mul_a   = div_x[63:32];
                        mul_b   = div_m[63:32];
                        mul_sel = 2'd2;
                    end
                    default:
                    begin
                        mul_sel = 2'd0;
                    end
                endcase
            end
            S_BACK:
            begin
                mul_a   = div_cnt_reg[0] ? div_q_reg[63:32] : div_q_reg[31:0];
                mul_b   = div_d;
                mul_sel = {1'b0, div_cnt_reg[0]};
            end
            default:
            begin
                mul_sel = 2'd0;
            end
        endcase
    end

    assign mul_p     = 64'(mul_a) * 64'(mul_b);
    assign mul_term  = (mul_sel == 2'd0) ? {64'd0, mul_p}
                     : (mul_sel == 2'd1) ? {32'd0, mul_p, 32'd0} : {mul_p, 64'd0};
    assign acc_next  = acc_reg + mul_term;
    assign div_q_est = div_by_sec_reg ? acc_next[SEC_POST_SHIFT +: 64]
                                      : acc_next[TEN_POST_SHIFT +: 64];
    // The reciprocal estimate is at most one below the true quotient.
    assign div_fix_ge  = div_rem_reg >= div_d;
    assign div_q_fix   = div_q_reg + {63'd0, div_fix_ge};
    assign div_rem_fix = div_fix_ge ? div_rem_reg - div_d : div_rem_reg;
    assign div_ns      = {div_rem_fix[29-SEC_PRE_SHIFT:0], div_num_reg[SEC_PRE_SHIFT-1:0]};

    assign bad_length = (packet_bytes < MIN_PACKET_BYTES)
                     || (packet_bytes >= 32'(MAX_PACKET_BYTES));
    assign rd_later   = {mem_rd_reg.sec, mem_rd_reg.ns} > {new_entry_reg.sec, new_entry_reg.ns};
    assign rel_qualifies = drain_all_reg || ({mem_rd_reg.sec, mem_rd_reg.ns} <= cutoff_reg);

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign status            = out_status_reg;
    assign sequence_event    = out_event_reg;
    assign lost_count        = out_lost_reg;
    assign stamp_seconds     = out_sec_reg;
    assign stamp_nanoseconds = out_ns_reg;
    assign record_length     = out_len_reg;
    assign record_handle     = out_handle_reg;
    assign last              = out_last_reg;

    always_comb
    begin
        mem_raddr = head_reg;
        mem_waddr = phys(head_reg, pos_reg);
        mem_wdata = new_entry_reg;
        mem_we    = 1'b0;
        case (state_reg)
            S_INS_RD:
            begin
                mem_raddr = phys(head_reg, CW'(pos_reg - 1'b1));
                mem_we    = (pos_reg == '0);
            end
            S_INS_CMP:
            begin
                mem_we = 1'b1;
                if (rd_later)
                begin
                    mem_wdata = mem_rd_reg;
                end
            end
            default:
            begin
                mem_raddr = head_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_rd_reg <= mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            check_seq_reg     <= 1'b0;
            flush_delay_reg   <= FLUSH_DELAY_RESET;
            anchor_tick_reg   <= '0;
            anchor_wall_reg   <= '0;
            expected_reg      <= '0;
            count_reg         <= '0;
            head_reg          <= '0;
            pos_reg           <= '0;
            released_reg      <= '0;
            drain_all_reg     <= 1'b0;
            timer_reg         <= 1'b0;
            pending_valid_reg <= 1'b0;
            pending_reg       <= '0;
            new_entry_reg     <= '0;
            cutoff_reg        <= '0;
            div_num_reg       <= '0;
            div_q_reg         <= '0;
            div_rem_reg       <= '0;
            acc_reg           <= '0;
            div_cnt_reg       <= '0;
            div_by_sec_reg    <= 1'b0;
            out_status_reg    <= ST_NONE;
            out_event_reg     <= EV_UNCHECKED;
            out_lost_reg      <= '0;
            out_sec_reg       <= '0;
            out_ns_reg        <= '0;
            out_len_reg       <= '0;
            out_handle_reg    <= '0;
            out_last_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_CHECK_SEQUENCE: check_seq_reg   <= cfg_data[0];
                    REG_FLUSH_DELAY:    flush_delay_reg <= cfg_data;
                    default:            check_seq_reg   <= check_seq_reg;
                endcase
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        released_reg      <= '0;
                        pending_valid_reg <= 1'b0;
                        drain_all_reg     <= (operation == OP_DRAIN);
                        timer_reg         <= (operation == OP_TICK);
                        acc_reg           <= '0;
                        div_cnt_reg       <= '0;
                        case (operation)
                            OP_PACKET:
                            begin
                                logic [1:0]  ev;
                                logic [15:0] lost;
                                ev   = EV_UNCHECKED;
                                lost = '0;
                                if (check_seq_reg)
                                begin
                                    if (sequence_number == expected_reg)
                                    begin
                                        ev           = EV_IN_ORDER;
                                        expected_reg <= sequence_number + 16'd1;
                                    end
                                    else if (expected_reg < sequence_number)
                                    begin
                                        ev           = EV_GAP;
                                        lost         = sequence_number - expected_reg;
                                        expected_reg <= sequence_number + 16'd1;
                                    end
                                    else
                                    begin
                                        ev = EV_DISORDER;
                                    end
                                end
                                new_entry_reg.len    <= packet_bytes[10:0];
                                new_entry_reg.handle <= payload_handle;
                                out_event_reg        <= ev;
                                out_lost_reg         <= lost;
                                out_handle_reg       <= payload_handle;
                                out_last_reg         <= 1'b1;
                                out_sec_reg          <= '0;
                                out_ns_reg           <= '0;
                                div_by_sec_reg       <= 1'b0;
                                if (bad_length)
                                begin
                                    out_status_reg <= ST_BAD_LENGTH;
                                    out_len_reg    <= '0;
                                    state_reg      <= S_OUT;
                                end
                                else if (anchor_tick_reg == '0)
                                begin
                                    anchor_tick_reg <= tick_stamp;
                                    anchor_wall_reg <= now_ns;
                                    div_num_reg     <= '0;
                                    state_reg       <= S_MUL;
                                end
                                else if (tick_stamp < anchor_tick_reg)
                                begin
                                    out_status_reg <= ST_BEFORE;
                                    out_len_reg    <= packet_bytes[10:0];
                                    state_reg      <= S_OUT;
                                end
                                else
                                begin
                                    div_num_reg <= (tick_stamp - anchor_tick_reg) << TICK_SHIFT;
                                    state_reg   <= S_MUL;
                                end
                            end
                            OP_TICK:
                            begin
                                div_num_reg    <= (now_ns >= 64'(flush_delay_reg))
                                                ? now_ns - 64'(flush_delay_reg) : '0;
                                div_by_sec_reg <= 1'b1;
                                state_reg      <= S_MUL;
                            end
                            OP_DRAIN:
                            begin
                                state_reg <= S_REL_RD;
                            end
                            default:
                            begin
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end

                S_MUL:
                begin
                    div_cnt_reg <= div_cnt_reg + 2'd1;
                    if (div_cnt_reg == 2'd3)
                    begin
                        div_q_reg <= div_q_est;
                        acc_reg   <= '0;
                        state_reg <= S_BACK;
                    end
                    else
                    begin
                        acc_reg <= acc_next;
                    end
                end

                S_BACK:
                begin
                    acc_reg <= acc_next;
                    if (div_cnt_reg == 2'd1)
                    begin
                        div_cnt_reg <= '0;
                        state_reg   <= S_REM;
                    end
                    else
                    begin
                        div_cnt_reg <= div_cnt_reg + 2'd1;
                    end
                end

                S_REM:
                begin
                    div_rem_reg <= 32'(div_x - acc_reg[63:0]);
                    state_reg   <= S_FIX;
                end

                S_FIX:
                begin
                    if (!div_by_sec_reg)
                    begin
                        div_q_reg <= div_q_fix;
                        state_reg <= S_SUM;
                    end
                    else if (timer_reg)
                    begin
                        cutoff_reg <= {div_q_fix[31:0], div_ns};
                        state_reg  <= S_REL_RD;
                    end
                    else
                    begin
                        new_entry_reg.sec <= div_q_fix[31:0];
                        new_entry_reg.ns  <= div_ns;
                        out_sec_reg       <= div_q_fix[31:0];
                        out_ns_reg        <= div_ns;
                        out_len_reg       <= new_entry_reg.len;
                        state_reg         <= S_PLACE;
                    end
                end

                S_SUM:
                begin
                    div_num_reg    <= div_q_reg + anchor_wall_reg;
                    acc_reg        <= '0;
                    div_cnt_reg    <= '0;
                    div_by_sec_reg <= 1'b1;
                    state_reg      <= S_MUL;
                end

                S_PLACE:
                begin
                    if (count_reg >= CW'(QUEUE_DEPTH))
                    begin
                        out_status_reg <= ST_FULL;
                        state_reg      <= S_OUT;
                    end
                    else
                    begin
                        pos_reg   <= count_reg;
                        state_reg <= S_INS_RD;
                    end
                end

                S_INS_RD:
                begin
                    if (pos_reg == '0)
                    begin
                        count_reg      <= count_reg + 1'b1;
                        out_status_reg <= ST_QUEUED;
                        state_reg      <= S_OUT;
                    end
                    else
                    begin
                        state_reg <= S_INS_CMP;
                    end
                end

                S_INS_CMP:
                begin
                    // A later stamp moves up one place; equal stamps keep arrival order.
                    if (rd_later)
                    begin
                        pos_reg   <= pos_reg - 1'b1;
                        state_reg <= S_INS_RD;
                    end
                    else
                    begin
                        count_reg      <= count_reg + 1'b1;
                        out_status_reg <= ST_QUEUED;
                        state_reg      <= S_OUT;
                    end
                end

                S_REL_RD:
                begin
                    if ((count_reg == '0) || (released_reg == NW'(MAX_RESULTS)))
                    begin
                        out_status_reg <= pending_valid_reg ? ST_RELEASED : ST_NONE;
                        out_event_reg  <= EV_UNCHECKED;
                        out_lost_reg   <= '0;
                        out_sec_reg    <= pending_valid_reg ? pending_reg.sec : '0;
                        out_ns_reg     <= pending_valid_reg ? pending_reg.ns : '0;
                        out_len_reg    <= pending_valid_reg ? pending_reg.len : '0;
                        out_handle_reg <= pending_valid_reg ? pending_reg.handle : '0;
                        out_last_reg   <= 1'b1;
                        state_reg      <= S_OUT;
                    end
                    else
                    begin
                        state_reg <= S_REL_EVAL;
                    end
                end

                S_REL_EVAL:
                begin
                    // The record held back goes out once it is known whether another follows.
                    if (rel_qualifies)
                    begin
                        pending_reg       <= mem_rd_reg;
                        pending_valid_reg <= 1'b1;
                        head_reg          <= phys(head_reg, CW'(1));
                        count_reg         <= count_reg - 1'b1;
                        released_reg      <= released_reg + 1'b1;
                    end
                    out_event_reg <= EV_UNCHECKED;
                    out_lost_reg  <= '0;
                    if (pending_valid_reg)
                    begin
                        out_status_reg <= ST_RELEASED;
                        out_sec_reg    <= pending_reg.sec;
                        out_ns_reg     <= pending_reg.ns;
                        out_len_reg    <= pending_reg.len;
                        out_handle_reg <= pending_reg.handle;
                        out_last_reg   <= !rel_qualifies;
                        state_reg      <= S_OUT;
                    end
                    else if (rel_qualifies)
                    begin
                        state_reg <= S_REL_RD;
                    end
                    else
                    begin
                        out_status_reg <= ST_NONE;
                        out_sec_reg    <= '0;
                        out_ns_reg     <= '0;
                        out_len_reg    <= '0;
                        out_handle_reg <= '0;
                        out_last_reg   <= 1'b1;
                        state_reg      <= S_OUT;
                    end
                end

                S_OUT:
                begin
                    if (out_ready)
                    begin
                        state_reg <= out_last_reg ? S_IDLE : S_REL_RD;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `CSTQ_ASSERT(a_count_bound, count_reg <= CW'(QUEUE_DEPTH), "store count above depth")
    `CSTQ_ASSERT(a_one_side, !(in_ready && out_valid), "input ready while a result waits")
    `CSTQ_ASSERT_NEXT(a_pop_count, (state_reg == S_REL_EVAL) && rel_qualifies,
        count_reg == CW'($past(count_reg) - 1'b1), "release did not pop one record")
    `CSTQ_ASSERT_NEXT(a_release_limit, out_valid && out_ready && !last,
        released_reg <= NW'(MAX_RESULTS), "too many records released")

endmodule
`default_nettype wire

FILE: tb/tb_capture_timestamp_reorder_queue.sv
// Self-checking testbench for the capture timestamp reorder queue.
`timescale 1ns / 1ps
`default_nettype none
module tb_capture_timestamp_reorder_queue;
    import cstq_pkg::*;

    localparam logic [63:0] STAMP_WRAP = 64'd4294967296000000000;
    localparam logic [63:0] NS_SEC     = 64'd1000000000;
    localparam int          CYCLE_LIMIT = 2000000;
    localparam int          SETTLE_CYCLES = 400;

    typedef struct {
        logic [1:0]  op;
        logic [63:0] tick;
        logic [31:0] bytes;
        logic [15:0] seq;
        logic [15:0] handle;
        logic [63:0] now;
        bit          known;
        logic [2:0]  known_status;
    } request_t;

    typedef struct {
        logic [2:0]  status;
        logic [1:0]  ev;
        logic [15:0] lost;
        logic [31:0] sec;
        logic [29:0] ns;
        logic [10:0] len;
        logic [15:0] handle;
        logic        last;
    } outcome_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_write;
    logic [0:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  operation;
    logic [63:0] tick_stamp;
    logic [31:0] packet_bytes;
    logic [15:0] sequence_number;
    logic [15:0] payload_handle;
    logic [63:0] now_ns;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  status;
    logic [1:0]  sequence_event;
    logic [15:0] lost_count;
    logic [31:0] stamp_seconds;
    logic [29:0] stamp_nanoseconds;
    logic [10:0] record_length;
    logic [15:0] record_handle;
    logic        last;

    capture_timestamp_reorder_queue dut (.*);

    // Predictor state.
    bit          seq_check_on;
    logic [31:0] flush_delay;
    logic [63:0] anchor_tick_p;
    logic [63:0] anchor_wall_p;
    logic [15:0] next_seq_p;
    logic [63:0] held_stamp[$];
    logic [10:0] held_len[$];
    logic [15:0] held_handle[$];
    outcome_t    pending[$];

    int  errors;
    int  cycles;
    bit  calm;
    logic [15:0] gen_seq;
    logic [63:0] recent_stamp;

    always begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    function automatic outcome_t make_outcome(logic [2:0] st, logic [1:0] ev, logic [15:0] lost,
                                              logic [63:0] stamp, logic [10:0] len,
                                              logic [15:0] handle, logic lst);
        outcome_t o;
        o.status = st;
        o.ev     = ev;
        o.lost   = lost;
        o.sec    = 32'(stamp / NS_SEC);
        o.ns     = 30'(stamp % NS_SEC);
        o.len    = len;
        o.handle = handle;
        o.last   = lst;
        return o;
    endfunction

    task automatic release_records(logic [63:0] cutoff, bit everything);
        int n;
        n = 0;
        while (n < MAX_RESULTS && held_stamp.size() > 0
               && (everything || held_stamp[0] <= cutoff)) begin
            pending.push_back(make_outcome(ST_RELEASED, EV_UNCHECKED, 16'd0, held_stamp[0],
                                           held_len[0], held_handle[0], 1'b0));
            void'(held_stamp.pop_front());
            void'(held_len.pop_front());
            void'(held_handle.pop_front());
            n++;
        end
        if (n == 0)
            pending.push_back(make_outcome(ST_NONE, EV_UNCHECKED, 16'd0, 64'd0, 11'd0,
                                           16'd0, 1'b1));
        else
            pending[pending.size() - 1].last = 1'b1;
    endtask

    task automatic predict_request(request_t r);
        logic [1:0]  ev;
        logic [15:0] lost;
        logic [63:0] stamp;
        logic [63:0] cutoff;
        outcome_t    o;
        int          pos;
        ev = EV_UNCHECKED;
        lost = 16'd0;
        if (r.op == OP_TICK) begin
            cutoff = (r.now >= 64'(flush_delay)) ? r.now - 64'(flush_delay) : 64'd0;
            release_records(cutoff % STAMP_WRAP, 1'b0);
            return;
        end
        if (r.op == OP_DRAIN) begin
            release_records(64'd0, 1'b1);
            return;
        end
        if (r.op != OP_PACKET)
            return;
        if (seq_check_on) begin
            if (r.seq == next_seq_p) begin
                ev = EV_IN_ORDER;
                next_seq_p = r.seq + 16'd1;
            end
            else if (next_seq_p < r.seq) begin
                ev = EV_GAP;
                lost = r.seq - next_seq_p;
                next_seq_p = r.seq + 16'd1;
            end
            else
                ev = EV_DISORDER;
        end
        if (r.bytes < MIN_PACKET_BYTES || r.bytes >= 32'(DEFAULT_MAX_PACKET_BYTES))
            o = make_outcome(ST_BAD_LENGTH, ev, lost, 64'd0, 11'd0, r.handle, 1'b1);
        else if (anchor_tick_p != 64'd0 && r.tick < anchor_tick_p)
            o = make_outcome(ST_BEFORE, ev, lost, 64'd0, r.bytes[10:0], r.handle, 1'b1);
        else begin
            if (anchor_tick_p == 64'd0) begin
                anchor_tick_p = r.tick;
                anchor_wall_p = r.now;
            end
            stamp = (anchor_wall_p + ((r.tick - anchor_tick_p) * 64'd64) / 64'd10)
                    % STAMP_WRAP;
            if (held_stamp.size() >= DEFAULT_QUEUE_DEPTH)
                o = make_outcome(ST_FULL, ev, lost, stamp, r.bytes[10:0], r.handle, 1'b1);
            else begin
                pos = held_stamp.size();
                while (pos > 0 && held_stamp[pos - 1] > stamp)
                    pos--;
                held_stamp.insert(pos, stamp);
                held_len.insert(pos, r.bytes[10:0]);
                held_handle.insert(pos, r.handle);
                recent_stamp = stamp;
                o = make_outcome(ST_QUEUED, ev, lost, stamp, r.bytes[10:0], r.handle, 1'b1);
            end
        end
        // Directed rows may carry a status read straight off the spec.
        if (r.known)
            o.status = r.known_status;
        pending.push_back(o);
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
        errors++;
    endtask

    always @(posedge clk) begin
        outcome_t w;
        if (rst_n) begin
            out_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 16);
            if (out_valid && out_ready) begin
                if (pending.size() == 0)
                    report_mismatch("unexpected result, status", 64'(status), 64'd0);
                else begin
                    w = pending.pop_front();
                    if (status !== w.status) report_mismatch("status", 64'(status), 64'(w.status));
                    if (sequence_event !== w.ev)
                        report_mismatch("sequence_event", 64'(sequence_event), 64'(w.ev));
                    if (lost_count !== w.lost)
                        report_mismatch("lost_count", 64'(lost_count), 64'(w.lost));
                    if (stamp_seconds !== w.sec)
                        report_mismatch("stamp_seconds", 64'(stamp_seconds), 64'(w.sec));
                    if (stamp_nanoseconds !== w.ns)
                        report_mismatch("stamp_nanoseconds", 64'(stamp_nanoseconds), 64'(w.ns));
                    if (record_length !== w.len)
                        report_mismatch("record_length", 64'(record_length), 64'(w.len));
                    if (record_handle !== w.handle)
                        report_mismatch("record_handle", 64'(record_handle), 64'(w.handle));
                    if (last !== w.last) report_mismatch("last", 64'(last), 64'(w.last));
                end
            end
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic send_request(request_t r);
        if (!calm && $urandom_range(0, 99) < 16) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        in_valid        <= 1'b1;
        operation       <= r.op;
        tick_stamp      <= r.tick;
        packet_bytes    <= r.bytes;
        sequence_number <= r.seq;
        payload_handle  <= r.handle;
        now_ns          <= r.now;
        do @(posedge clk); while (!in_ready);
        predict_request(r);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (pending.size() != 0)
            @(posedge clk);
        // Ignored requests give no result, so allow the longest latency to pass.
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_registers(bit chk, logic [31:0] delay);
        cfg_write <= 1'b1;
        cfg_index <= REG_CHECK_SEQUENCE;
        cfg_data  <= {31'd0, chk};
        @(posedge clk);
        cfg_index <= REG_FLUSH_DELAY;
        cfg_data  <= delay;
        @(posedge clk);
        cfg_write <= 1'b0;
        seq_check_on = chk;
        flush_delay  = delay;
    endtask

    function automatic request_t random_request(bit packets_only);
        request_t r;
        int pick;
        pick = packets_only ? 0 : $urandom_range(0, 99);
        r.known  = 1'b0;
        r.known_status = ST_QUEUED;
        r.handle = 16'($urandom);
        r.seq    = 16'($urandom);
        r.bytes  = 32'($urandom_range(60, 2047));
        r.tick   = anchor_tick_p + 64'($urandom_range(0, 1 << 20));
        r.now    = {$urandom, $urandom};
        if (pick < 72) begin
            r.op = OP_PACKET;
            case ($urandom_range(0, 9))
                0: r.bytes = 32'($urandom_range(0, 59));
                1: r.bytes = $urandom;
                default: ;
            endcase
            case ($urandom_range(0, 19))
                0: r.tick = {$urandom, $urandom};
                1: r.tick = anchor_tick_p - 64'($urandom_range(1, 100));
                default: ;
            endcase
            case ($urandom_range(0, 9))
                0, 1: r.seq = gen_seq + 16'($urandom_range(1, 60));
                2: ;
                3: r.seq = gen_seq - 16'($urandom_range(1, 60));
                default: r.seq = gen_seq;
            endcase
            if (r.seq >= gen_seq)
                gen_seq = r.seq + 16'd1;
        end
        else if (pick < 88) begin
            r.op = OP_TICK;
            if ($urandom_range(0, 5) != 0)
                r.now = recent_stamp + 64'(flush_delay) - 64'd8388608
                        + 64'($urandom_range(0, 1 << 24));
        end
        else if (pick < 96)
            r.op = OP_DRAIN;
        else
            r.op = 2'd3;
        return r;
    endfunction

    task automatic random_phase(int fill, int count);
        for (int i = 0; i < fill + count; i++) begin
            calm = (i >= fill + count / 3 && i < fill + count / 3 + 12);
            send_request(random_request(i < fill));
        end
        calm = 1'b0;
    endtask

    request_t directed[] = '{
        '{OP_DRAIN,  64'd0, 32'd0, 16'd0, 16'h0000, 64'd0, 1'b1, ST_NONE},
        '{OP_TICK,   64'd0, 32'd0, 16'd0, 16'h0000, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, ST_NONE},
        '{OP_PACKET, 64'd5, 32'd59, 16'd0, 16'hFFFF, 64'd0, 1'b1, ST_BAD_LENGTH},
        '{OP_PACKET, 64'd5, 32'd2048, 16'hFFFF, 16'h0001, 64'd0, 1'b1, ST_BAD_LENGTH},
        '{OP_PACKET, 64'd5, 32'hFFFF_FFFF, 16'd1, 16'h0002, 64'd0, 1'b1, ST_BAD_LENGTH},
        // A zero tick stamp does not anchor the queue.
        '{OP_PACKET, 64'd0, 32'd60, 16'd2, 16'h0003, 64'd5, 1'b1, ST_QUEUED},
        '{OP_PACKET, 64'd1000, 32'd2047, 16'd3, 16'h0004, 64'd1000000000, 1'b1, ST_QUEUED},
        '{OP_PACKET, 64'd999, 32'd100, 16'd4, 16'h0005, 64'd0, 1'b1, ST_BEFORE},
        '{OP_PACKET, 64'hFFFF_FFFF_FFFF_FFFF, 32'd61, 16'd5, 16'h0006, 64'd0, 1'b1, ST_QUEUED},
        '{OP_PACKET, 64'd1000, 32'd500, 16'd6, 16'h0007, 64'd0, 1'b1, ST_QUEUED},
        '{OP_PACKET, 64'd1010, 32'd64, 16'd7, 16'h0008, 64'd0, 1'b0, ST_QUEUED},
        '{2'd3,      64'd1, 32'd100, 16'd8, 16'h0009, 64'd1, 1'b0, ST_QUEUED},
        '{OP_TICK,   64'd0, 32'd0, 16'd0, 16'h0000, 64'd0, 1'b0, ST_QUEUED},
        '{OP_TICK,   64'd0, 32'd0, 16'd0, 16'h0000, 64'd1500000100, 1'b0, ST_QUEUED},
        '{OP_TICK,   64'd0, 32'd0, 16'd0, 16'h0000, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, ST_QUEUED},
        '{OP_DRAIN,  64'd0, 32'd0, 16'd0, 16'h0000, 64'd0, 1'b0, ST_QUEUED},
        '{OP_DRAIN,  64'd0, 32'd0, 16'd0, 16'h0000, 64'd0, 1'b1, ST_NONE}
    };

    initial begin
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = REG_CHECK_SEQUENCE;
        cfg_data = 32'd0;
        in_valid = 1'b0;
        operation = OP_PACKET;
        tick_stamp = 64'd0;
        packet_bytes = 32'd0;
        sequence_number = 16'd0;
        payload_handle = 16'd0;
        now_ns = 64'd0;
        out_ready = 1'b0;
        errors = 0;
        cycles = 0;
        calm = 1'b0;
        gen_seq = 16'd0;
        recent_stamp = 64'd0;
        seq_check_on = 1'b0;
        flush_delay = FLUSH_DELAY_RESET;
        anchor_tick_p = 64'd0;
        anchor_wall_p = 64'd0;
        next_seq_p = 16'd0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_request(directed[i]);
        settle();

        write_registers(1'b1, 32'd0);
        random_phase(36, 30);
        settle();
        write_registers(1'b1, 32'hFFFF_FFFF);
        random_phase(0, 40);
        settle();
        write_registers(1'b0, 32'd1000);
        random_phase(34, 10);
        settle();

        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
`default_nettype wire
